>>> hw/rtl/i2p_pkg.sv
`timescale 1ns / 1ps

package i2p_pkg;

  localparam int STACK_DEPTH = 32;
  localparam int TOP_W       = $clog2(STACK_DEPTH);

  localparam logic [7:0] CH_CLOSE = 8'h29;
  localparam logic [7:0] CH_OPEN  = 8'h28;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_CARET = 8'h5E;

  typedef enum logic [1:0] {
    ERR_NONE     = 2'd0,
    ERR_OVERFLOW = 2'd1,
    ERR_PAREN    = 2'd2
  } err_code_t;

  typedef enum logic [1:0] {
    CLS_OPERAND,
    CLS_CLOSE,
    CLS_OPEN,
    CLS_OPER
  } char_class_t;

  typedef enum logic [2:0] {
    SEL_TOP,
    SEL_IN,
    SEL_END,
    SEL_OVF,
    SEL_PAREN
  } emit_sel_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic      load;
    logic      push;
    logic      pop;
    logic      clear;
    logic      set_hold;
    logic      emit;
    emit_sel_t sel;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic        cmd;
    logic        hold;
    char_class_t cls;
    logic        top_base;
    logic        top_mark;
    logic        top_gt;
    logic        full;
    logic        can_emit;
  } dp_stat_t;

  function automatic logic [1:0] prec(input logic [7:0] c);
    logic [1:0] p;
    unique case (c) inside
      CH_PLUS, CH_MINUS: p = 2'd1;
      CH_STAR, CH_SLASH: p = 2'd2;
      CH_CARET:          p = 2'd3;
      default:           p = 2'd0;
    endcase
    return p;
  endfunction

  function automatic char_class_t classify(input logic [7:0] c);
    char_class_t k;
    if ((c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A) ||
        (c >= 8'h30 && c <= 8'h39)) begin
      k = CLS_OPERAND;
    end else if (c == CH_CLOSE) begin
      k = CLS_CLOSE;
    end else if (c == CH_OPEN) begin
      k = CLS_OPEN;
    end else begin
      k = CLS_OPER;
    end
    return k;
  endfunction

endpackage

>>> hw/rtl/i2p_datapath.sv
`timescale 1ns / 1ps

module i2p_datapath (
  input  logic               clk,
  input  logic               rst_n,
  input  i2p_pkg::dp_cmd_t   cmd,
  output i2p_pkg::dp_stat_t  stat,
  input  logic               in_cmd,
  input  logic [7:0]         in_sym,
  input  logic               out_ready,
  output logic               out_valid,
  output logic [7:0]         out_sym,
  output logic               out_end,
  output logic [1:0]         out_err
);

  logic                      cmd_r;
  logic [7:0]                sym_r;
  logic [i2p_pkg::TOP_W-1:0] top_r, top_nxt;
  logic                      hold_r, hold_nxt;
  logic [7:0]                stack_r [i2p_pkg::STACK_DEPTH];
  logic [7:0]                top_sym;

  logic                      out_valid_r, out_valid_nxt;
  logic [7:0]                out_sym_r, out_sym_nxt;
  logic                      out_end_r, out_end_nxt;
  logic [1:0]                out_err_r, out_err_nxt;

  // Entry 0 is the base marker and is never written.
  assign top_sym = (top_r == '0) ? i2p_pkg::CH_CLOSE : stack_r[top_r];

  always_comb begin
    stat.cmd      = cmd_r;
    stat.hold     = hold_r;
    stat.cls      = i2p_pkg::classify(sym_r);
    stat.top_base = (top_r == '0);
    stat.top_mark = (top_sym == i2p_pkg::CH_CLOSE);
    stat.top_gt   = (i2p_pkg::prec(top_sym) > i2p_pkg::prec(sym_r));
    stat.full     = (top_r == i2p_pkg::TOP_W'(i2p_pkg::STACK_DEPTH - 1));
    stat.can_emit = !out_valid_r || out_ready;
  end

  always_comb begin
    top_nxt  = top_r;
    hold_nxt = hold_r;
    if (cmd.clear) begin
      top_nxt  = '0;
      hold_nxt = 1'b0;
    end else begin
      if (cmd.push) begin
        top_nxt = top_r + i2p_pkg::TOP_W'(1);
      end else if (cmd.pop) begin
        top_nxt = top_r - i2p_pkg::TOP_W'(1);
      end
      if (cmd.set_hold) begin
        hold_nxt = 1'b1;
      end
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_sym_nxt   = out_sym_r;
    out_end_nxt   = out_end_r;
    out_err_nxt   = out_err_r;
    if (cmd.emit) begin
      out_valid_nxt = 1'b1;
      out_sym_nxt   = 8'h00;
      out_end_nxt   = 1'b0;
      out_err_nxt   = i2p_pkg::ERR_NONE;
      case (cmd.sel)
        i2p_pkg::SEL_TOP:   out_sym_nxt = top_sym;
        i2p_pkg::SEL_IN:    out_sym_nxt = sym_r;
        i2p_pkg::SEL_END:   out_end_nxt = 1'b1;
        i2p_pkg::SEL_OVF:   out_err_nxt = i2p_pkg::ERR_OVERFLOW;
        i2p_pkg::SEL_PAREN: out_err_nxt = i2p_pkg::ERR_PAREN;
        default:            out_sym_nxt = 8'h00;
      endcase
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      top_r       <= '0;
      hold_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      top_r       <= top_nxt;
      hold_r      <= hold_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cmd_r <= in_cmd;
      sym_r <= in_sym;
    end
    if (cmd.push) begin
      stack_r[top_r + i2p_pkg::TOP_W'(1)] <= sym_r;
    end
    out_sym_r <= out_sym_nxt;
    out_end_r <= out_end_nxt;
    out_err_r <= out_err_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_sym   = out_sym_r;
  assign out_end   = out_end_r;
  assign out_err   = out_err_r;

  a_top_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    top_r <= i2p_pkg::TOP_W'(i2p_pkg::STACK_DEPTH - 1))
    else $error("stack pointer beyond last entry");

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.push |-> !stat.full)
    else $error("push on a full stack");

  a_no_pop_base: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.pop |-> !stat.top_base)
    else $error("pop of the base marker");

  a_emit_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> stat.can_emit)
    else $error("result written over an unread result");

  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.clear |=> (top_r == '0) && !hold_r)
    else $error("stack not reset after end of expression");

endmodule

>>> hw/rtl/i2p_ctrl.sv
`timescale 1ns / 1ps

module i2p_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  i2p_pkg::dp_stat_t stat,
  output i2p_pkg::dp_cmd_t  cmd
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_WORK = 2'b10
  } state_t;

  state_t state_r, state_nxt;
  logic   can_pop;

  // A pop that emits stops at any close marker, base or not.
  assign can_pop  = !stat.top_base && !stat.top_mark;
  assign in_ready = (state_r == ST_IDLE);

  always_comb begin
    state_nxt    = state_r;
    cmd          = '0;
    cmd.sel      = i2p_pkg::SEL_TOP;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_WORK;
        end
      end
      ST_WORK: begin
        if (stat.cmd) begin
          if (!stat.hold && can_pop) begin
            if (stat.can_emit) begin
              cmd.emit = 1'b1;
              cmd.pop  = 1'b1;
            end
          end else if (stat.can_emit) begin
            cmd.emit  = 1'b1;
            cmd.sel   = i2p_pkg::SEL_END;
            cmd.clear = 1'b1;
            state_nxt = ST_IDLE;
          end
        end else if (stat.hold) begin
          state_nxt = ST_IDLE;
        end else begin
          case (stat.cls)
            i2p_pkg::CLS_OPERAND: begin
              if (stat.can_emit) begin
                cmd.emit  = 1'b1;
                cmd.sel   = i2p_pkg::SEL_IN;
                state_nxt = ST_IDLE;
              end
            end
            i2p_pkg::CLS_OPEN: begin
              if (can_pop) begin
                if (stat.can_emit) begin
                  cmd.emit = 1'b1;
                  cmd.pop  = 1'b1;
                end
              end else if (stat.top_base) begin
                if (stat.can_emit) begin
                  cmd.emit     = 1'b1;
                  cmd.sel      = i2p_pkg::SEL_PAREN;
                  cmd.set_hold = 1'b1;
                  state_nxt    = ST_IDLE;
                end
              end else begin
                // Drop the matching close marker.
                cmd.pop   = 1'b1;
                state_nxt = ST_IDLE;
              end
            end
            default: begin
              // Operators pop higher precedence first; a close marker only pushes.
              if (stat.cls == i2p_pkg::CLS_OPER && !stat.top_base && stat.top_gt) begin
                if (stat.can_emit) begin
                  cmd.emit = 1'b1;
                  cmd.pop  = 1'b1;
                end
              end else if (stat.full) begin
                if (stat.can_emit) begin
                  cmd.emit     = 1'b1;
                  cmd.sel      = i2p_pkg::SEL_OVF;
                  cmd.set_hold = 1'b1;
                  state_nxt    = ST_IDLE;
                end
              end else begin
                cmd.push  = 1'b1;
                state_nxt = ST_IDLE;
              end
            end
          endcase
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |-> (state_r == ST_IDLE))
    else $error("item loaded while busy");

  a_load_work: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> (state_r == ST_WORK))
    else $error("loaded item not processed");

  a_work_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> !cmd.emit && !cmd.push && !cmd.pop && !cmd.clear)
    else $error("stack or result command while idle");

endmodule

>>> hw/rtl/infix_to_prefix_converter.sv
`timescale 1ns / 1ps

// Infix to prefix converter, shunting-yard style, working right to left.
// The host sends the characters of an infix expression last to first on the
// in_ stream, one item per character, and receives the prefix form in reverse
// on the out_ stream, one symbol per item. An item with in_tuser set ends the
// expression: the remaining operators above the nearest ')' come out, then an
// item with out_tlast set, and the operator stack returns to its reset state.
// Errors (stack overflow, '(' without a matching ')') give one item with a
// nonzero code on out_tuser; later characters give nothing until the end item.
// Flow: an item is taken while the controller is idle; the controller then
// pops operators from the stack one entry per cycle while the receiver
// takes results, and a final step finishes the item and returns to idle; no
// new character is taken before that.
// Results leave through an output register; when the receiver stalls, the
// controller waits before writing the next result, and no item is lost.
// Synchronous active-low reset empties the stack to its ')' base marker,
// clears the error hold and drops any pending result.

module infix_to_prefix_converter (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] symbol
  input  logic [0:0] in_tuser,   // [0] command (1 = end of expression)
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [7:0] out_symbol
  output logic       out_tlast,  // is_end
  output logic [1:0] out_tuser   // [1:0] error_code
);

  i2p_pkg::dp_cmd_t  cmd;
  i2p_pkg::dp_stat_t stat;

  i2p_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  i2p_datapath u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .stat      (stat),
    .in_cmd    (in_tuser[0]),
    .in_sym    (in_tdata),
    .out_ready (out_tready),
    .out_valid (out_tvalid),
    .out_sym   (out_tdata),
    .out_end   (out_tlast),
    .out_err   (out_tuser)
  );

endmodule

>>> dv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

  // Worst case is every item popping a full stack through a stalled receiver,
  // so this bound is several times the slowest legal run.
  localparam int CYCLE_LIMIT = 1000000;
  localparam int ITEM_TARGET = 250;
  // Cycles the receiver refuses results once, so the block backs up.
  localparam int SQUEEZE_CYCLES = 400;
  localparam int SQUEEZE_AFTER  = 120;
  // The pop loop of a full stack plus margin for stray results.
  localparam int DRAIN_CYCLES = 64;

  // Scoreboard of the converter. Every accepted input item goes through
  // take_char, which extends the queue of symbols the block must emit next.
  class prefix_checker;
    typedef struct packed {
      logic [7:0]         sym;
      logic               last;
      i2p_pkg::err_code_t err;
    } sym_result_t;

    logic [7:0]  op_stack [i2p_pkg::STACK_DEPTH];
    int          depth;
    bit          hold;
    sym_result_t expected_syms [$];
    int          mismatches;

    function new();
      clear_stack();
      hold       = 1'b0;
      mismatches = 0;
    endfunction

    function void clear_stack();
      foreach (op_stack[i]) op_stack[i] = 8'h00;
      op_stack[0] = i2p_pkg::CH_CLOSE;
      depth       = 0;
    endfunction

    function int rank(logic [7:0] c);
      if (c == i2p_pkg::CH_CARET) return 3;
      if (c == i2p_pkg::CH_STAR || c == i2p_pkg::CH_SLASH) return 2;
      if (c == i2p_pkg::CH_PLUS || c == i2p_pkg::CH_MINUS) return 1;
      return 0;
    endfunction

    function bit is_operand(logic [7:0] c);
      return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z") ||
             (c >= "0" && c <= "9");
    endfunction

    function void emit(logic [7:0] sym, logic last, i2p_pkg::err_code_t err);
      sym_result_t r;
      r.sym  = sym;
      r.last = last;
      r.err  = err;
      expected_syms.push_back(r);
    endfunction

    function void pop_emit();
      emit(op_stack[depth], 1'b0, i2p_pkg::ERR_NONE);
      depth--;
    endfunction

    // A push onto a full stack raises the overflow error and the hold.
    function void push_or_fail(logic [7:0] c);
      if (depth >= i2p_pkg::STACK_DEPTH - 1) begin
        emit(8'h00, 1'b0, i2p_pkg::ERR_OVERFLOW);
        hold = 1'b1;
      end else begin
        depth++;
        op_stack[depth] = c;
      end
    endfunction

    function void take_char(bit cmd, logic [7:0] c);
      int p;
      if (cmd) begin
        // End of expression: flush above the nearest ')', unless held.
        if (!hold) begin
          while (depth > 0 && op_stack[depth] != i2p_pkg::CH_CLOSE) pop_emit();
        end
        emit(8'h00, 1'b1, i2p_pkg::ERR_NONE);
        clear_stack();
        hold = 1'b0;
        return;
      end
      if (hold) return;
      if (is_operand(c)) begin
        emit(c, 1'b0, i2p_pkg::ERR_NONE);
      end else if (c == i2p_pkg::CH_CLOSE) begin
        push_or_fail(c);
      end else if (c == i2p_pkg::CH_OPEN) begin
        while (depth > 0 && op_stack[depth] != i2p_pkg::CH_CLOSE) pop_emit();
        if (depth == 0) begin
          // Only the base marker is left: the '(' has no partner.
          emit(8'h00, 1'b0, i2p_pkg::ERR_PAREN);
          hold = 1'b1;
        end else begin
          depth--;
        end
      end else begin
        p = rank(c);
        while (depth > 0 && rank(op_stack[depth]) > p) pop_emit();
        push_or_fail(c);
      end
    endfunction

    task report(string msg);
      mismatches++;
      if (mismatches <= 40) $display("ERROR @%0t: %s", $realtime, msg);
    endtask

    task check_result(logic [7:0] sym, logic last, logic [1:0] err);
      sym_result_t want;
      if (expected_syms.size() == 0) begin
        report($sformatf("result with nothing expected: sym=%h last=%b err=%0d",
                         sym, last, err));
        return;
      end
      want = expected_syms.pop_front();
      if (sym !== want.sym)
        report($sformatf("out_symbol %h, expected %h", sym, want.sym));
      if (last !== want.last)
        report($sformatf("is_end %b, expected %b", last, want.last));
      if (err !== want.err)
        report($sformatf("error_code %0d, expected %0d", err, want.err));
    endtask

    function int pending();
      return expected_syms.size();
    endfunction
  endclass

  logic       clk;
  logic       rst_n;
  logic       in_tvalid;
  logic       in_tready;
  logic [7:0] in_tdata;   // [7:0] symbol
  logic [0:0] in_tuser;   // [0] command (1 = end of expression)
  logic       out_tvalid;
  logic       out_tready;
  logic [7:0] out_tdata;  // [7:0] out_symbol
  logic       out_tlast;  // is_end
  logic [1:0] out_tuser;  // [1:0] error_code

  prefix_checker sb = new();

  // Infix text under construction, written left to right, fed right to left.
  logic [7:0] expr_q [$];
  int         items_sent;
  int         items_taken;
  int         in_calm;

  infix_to_prefix_converter DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Both monitors sample at the rising edge, before the block's registers
  // update, so an item counts exactly when tvalid and tready were both high.
  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) begin
      sb.take_char(in_tuser[0], in_tdata);
      items_taken++;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      sb.check_result(out_tdata, out_tlast, out_tuser);
    end
  end

  // Idle length: mostly none or short, now and then long. A calm stretch
  // suppresses idling altogether for a run of decisions.
  function automatic int pick_idle(ref int calm);
    int r;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) begin
      calm = $urandom_range(20, 40);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 16);
  endfunction

  // Receiver: random stalls, plus one long refusal once enough items went in,
  // while the sender keeps offering so the block fills up and stalls in_.
  initial begin : receiver
    int stall_left;
    int calm;
    bit squeezed;
    stall_left = 0;
    calm       = 0;
    squeezed   = 1'b0;
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (!squeezed && items_taken >= SQUEEZE_AFTER) begin
        squeezed   = 1'b1;
        stall_left = SQUEEZE_CYCLES;
      end else if (stall_left == 0 && $urandom_range(0, 99) < 35) begin
        stall_left = pick_idle(calm);
      end
      if (!rst_n || stall_left > 0) begin
        out_tready <= 1'b0;
        if (stall_left > 0) stall_left--;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // Offer one item after a random gap and hold it until the block takes it.
  task automatic send_char(input bit cmd, input logic [7:0] c);
    int gap;
    gap = pick_idle(in_calm);
    if (gap > 0) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= c;
    do @(posedge clk); while (!in_tready);
    items_sent++;
  endtask

  function automatic logic [7:0] pick_operand();
    case ($urandom_range(0, 2))
      0:       return 8'("A" + $urandom_range(0, 25));
      1:       return 8'("a" + $urandom_range(0, 25));
      default: return 8'("0" + $urandom_range(0, 9));
    endcase
  endfunction

  // Mostly the five real operators; sometimes a stray byte, which the block
  // treats as an operator of the lowest precedence.
  function automatic logic [7:0] pick_operator();
    case ($urandom_range(0, 11))
      0, 1:    return i2p_pkg::CH_PLUS;
      2, 3:    return i2p_pkg::CH_MINUS;
      4, 5:    return i2p_pkg::CH_STAR;
      6, 7:    return i2p_pkg::CH_SLASH;
      8, 9:    return i2p_pkg::CH_CARET;
      10:      return 8'h20;
      default: return ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00;
    endcase
  endfunction

  // Builds a random well-formed infix expression into expr_q.
  task automatic add_expr(input int levels);
    int r;
    r = $urandom_range(0, 99);
    if (levels == 0 || r < 35) begin
      expr_q.push_back(pick_operand());
    end else if (r < 55) begin
      expr_q.push_back(i2p_pkg::CH_OPEN);
      add_expr(levels - 1);
      expr_q.push_back(i2p_pkg::CH_CLOSE);
    end else begin
      add_expr(levels - 1);
      expr_q.push_back(pick_operator());
      add_expr(levels - 1);
    end
  endtask

  // The block wants the expression last character first.
  task automatic feed_expr();
    for (int i = expr_q.size() - 1; i >= 0; i--) send_char(1'b0, expr_q[i]);
    expr_q.delete();
  endtask

  task automatic feed_infix(input string s);
    for (int i = 0; i < s.len(); i++) expr_q.push_back(s[i]);
    feed_expr();
  endtask

  task automatic end_expr();
    send_char(1'b1, 8'($urandom_range(0, 255)));
  endtask

  // A long chain of pushes, either plain ')' or right-associative '^'. Past
  // the stack's free entries it overflows; otherwise a '+' after a '^' chain pops it all.
  task automatic feed_deep_chain();
    int  n;
    bit  carets;
    n      = $urandom_range(28, i2p_pkg::STACK_DEPTH + 1);
    carets = 1'($urandom_range(0, 1));
    for (int i = 0; i < n; i++)
      send_char(1'b0, carets ? i2p_pkg::CH_CARET : i2p_pkg::CH_CLOSE);
    if (carets) send_char(1'b0, i2p_pkg::CH_PLUS);
    end_expr();
  endtask

  // A valid expression with one parenthesis added or one character removed.
  task automatic feed_broken_expr();
    int pos;
    add_expr($urandom_range(1, 3));
    pos = $urandom_range(0, expr_q.size() - 1);
    case ($urandom_range(0, 2))
      0:       expr_q.insert(pos, i2p_pkg::CH_OPEN);
      1:       expr_q.insert(pos, i2p_pkg::CH_CLOSE);
      default: expr_q.delete(pos);
    endcase
    feed_expr();
    end_expr();
  endtask

  task automatic feed_noise();
    int n;
    n = $urandom_range(3, 10);
    for (int i = 0; i < n; i++)
      send_char($urandom_range(0, 7) == 0, 8'($urandom_range(0, 255)));
  endtask

  initial begin : watchdog
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin : main
    int r;
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = 8'h00;
    in_tuser    = 1'b0;
    items_sent  = 0;
    items_taken = 0;
    in_calm     = 0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: every operator and parentheses with operand extremes, then an
    // end on an empty stack.
    feed_infix("(A-z)*9/Z^0+a");
    end_expr();
    send_char(1'b1, 8'hFF);
    // A '(' with no ')' on the stack: '+' is flushed, then the error, and the
    // trailing 'x' is ignored under the hold.
    feed_infix("x(+q");
    end_expr();
    // Stray bytes stack up as lowest-precedence operators.
    send_char(1'b0, 8'h00);
    send_char(1'b0, 8'hFF);
    send_char(1'b0, 8'h20);
    send_char(1'b0, i2p_pkg::CH_STAR);
    end_expr();

    // Random: mostly well-formed expressions, some deep chains near or past the
    // stack limit, some broken parentheses and some raw noise.
    while (items_sent < ITEM_TARGET) begin
      r = $urandom_range(0, 99);
      if (r < 62) begin
        add_expr($urandom_range(0, 4));
        feed_expr();
        end_expr();
      end else if (r < 72) begin
        feed_deep_chain();
      end else if (r < 86) begin
        feed_broken_expr();
      end else begin
        feed_noise();
      end
    end
    @(negedge clk);
    in_tvalid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
